// ===== hdl/ppa_pkg.sv =====
package ppa_pkg;

   localparam int CHAN_W      = 8;
   localparam int FIELD_W     = 10;
   localparam int PIXEL_W     = 28;
   localparam int COLOR_W     = 24;
   localparam int SHIFT_W     = 4;
   localparam int LEVEL_W     = 5;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CHAN_W-1:0]  CHAN_MAX    = 8'hFF;
   localparam logic [LEVEL_W:0]   BLEND_TOTAL = 6'd32;

   localparam logic [CSR_INDEX_W-1:0] CSR_CONST_COLOR  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT_AMOUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLEND_LEVEL  = 2'd2;

   typedef enum logic [2:0] {
      OP_ADD_CONST = 3'd0,
      OP_SUB_CONST = 3'd1,
      OP_SHIFT     = 3'd2,
      OP_AVERAGE   = 3'd3,
      OP_ADD_HALF  = 3'd4,
      OP_BLUR      = 3'd5
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [SHIFT_W-1:0]   shift;
      logic [LEVEL_W-1:0]   level;
      logic                 seed;
   } chan_ctl_type;

endpackage

// ===== hdl/ppa_chan.sv =====
module ppa_chan
   import ppa_pkg::*;
(
   input  chan_ctl_type        ctl,
   input  logic [CHAN_W-1:0]   dst,
   input  logic [CHAN_W-1:0]   src,
   input  logic [CHAN_W-1:0]   color,
   input  logic [CHAN_W-1:0]   run,
   output logic [CHAN_W-1:0]   result
);

   logic [CHAN_W:0]    add_sum;
   logic [CHAN_W:0]    half_sum;
   logic [CHAN_W:0]    avg_sum;
   logic [CHAN_W-1:0]  run_sel;
   logic [LEVEL_W:0]   in_weight;
   logic [10:0]        run_part;
   logic [10:0]        in_part;
   logic [10:0]        blend;

   assign add_sum  = {1'b0, dst} + {1'b0, color};
   assign half_sum = {1'b0, dst} + {2'b00, src[CHAN_W-1:1]};
   assign avg_sum  = {1'b0, dst} + {1'b0, src};

   // row start seeds the run with half the pixel
   assign run_sel   = ctl.seed ? {1'b0, dst[CHAN_W-1:1]} : run;
   assign in_weight = BLEND_TOTAL - {1'b0, ctl.level};
   assign run_part  = {6'b0, run_sel[CHAN_W-1:3]} * {6'b0, ctl.level};
   assign in_part   = {6'b0, dst[CHAN_W-1:3]} * {5'b0, in_weight};
   assign blend     = run_part + in_part;

   always_comb begin
      unique case (ctl.op)
         OP_ADD_CONST: begin
            result = add_sum[CHAN_W] ? CHAN_MAX : add_sum[CHAN_W-1:0];
         end
         OP_SUB_CONST: begin
            result = (dst >= color) ? (dst - color) : '0;
         end
         OP_SHIFT: begin
            // amounts of eight and above shift everything out
            result = dst >> ctl.shift;
         end
         OP_AVERAGE: begin
            result = avg_sum[CHAN_W:1];
         end
         OP_ADD_HALF: begin
            result = half_sum[CHAN_W] ? CHAN_MAX : half_sum[CHAN_W-1:0];
         end
         OP_BLUR: begin
            result = blend[9:2];
         end
         default: begin
            result = dst;
         end
      endcase
   end

endmodule

// ===== hdl/packed_pixel_alu.sv =====
// Packed pixel ALU: one pixel (three 8-bit channels in 10-bit fields) enters per
// cycle unless a stalled result backs up into the input register; an input register
// and a result register frame a single combinational pass, and the blur run
// register closes its loop inside that pass, so back-to-back blur pixels need no
// bubbles. Configuration writes take effect at once and must only happen while
// the block holds no pixel.
module packed_pixel_alu
   import ppa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [55:0]             req_tdata,   // dst_pixel, src_pixel
   input  logic [3:0]              req_tuser,   // operation, row_start
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata,   // result_pixel
   output logic                    rsp_tlast,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [COLOR_W-1:0]      csr_wdata
);

   logic [COLOR_W-1:0]  const_color_ff;
   logic [SHIFT_W-1:0]  shift_amount_ff;
   logic [LEVEL_W-1:0]  blend_level_ff;
   logic [COLOR_W-1:0]  blur_run_ff;
   logic [COLOR_W-1:0]  blur_run_in;

   logic                s1_valid_ff;
   op_type              s1_op_ff;
   logic [PIXEL_W-1:0]  s1_dst_ff;
   logic [PIXEL_W-1:0]  s1_src_ff;
   logic                s1_seed_ff;
   logic                s1_last_ff;

   logic                s2_valid_ff;
   logic [PIXEL_W-1:0]  s2_pixel_ff;
   logic [PIXEL_W-1:0]  s2_pixel_in;
   logic                s2_last_ff;

   logic                req_xfer;
   logic                s1_advance;
   chan_ctl_type        chan_ctl;
   logic [CHAN_W-1:0]   chan_res [3];

   assign req_xfer   = req_tvalid && req_tready;
   assign s1_advance = s1_valid_ff && (!s2_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;

   assign chan_ctl.op    = s1_op_ff;
   assign chan_ctl.shift = shift_amount_ff;
   assign chan_ctl.level = blend_level_ff;
   assign chan_ctl.seed  = s1_seed_ff;

   for (genvar k = 0; k < 3; k++) begin : g_chan
      ppa_chan u_chan (
         .ctl    (chan_ctl),
         .dst    (s1_dst_ff[FIELD_W*k +: CHAN_W]),
         .src    (s1_src_ff[FIELD_W*k +: CHAN_W]),
         .color  (const_color_ff[CHAN_W*k +: CHAN_W]),
         .run    (blur_run_ff[CHAN_W*k +: CHAN_W]),
         .result (chan_res[k])
      );
   end

   assign s2_pixel_in = {chan_res[2], 2'b00, chan_res[1], 2'b00, chan_res[0]};
   assign blur_run_in = {chan_res[2], chan_res[1], chan_res[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         const_color_ff  <= '0;
         shift_amount_ff <= '0;
         blend_level_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CONST_COLOR:  const_color_ff  <= csr_wdata;
            CSR_SHIFT_AMOUNT: shift_amount_ff <= csr_wdata[SHIFT_W-1:0];
            CSR_BLEND_LEVEL:  blend_level_ff  <= csr_wdata[LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blur_run_ff <= '0;
      end else if (s1_advance && s1_op_ff == OP_BLUR) begin
         blur_run_ff <= blur_run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_op_ff   <= op_type'(req_tuser[2:0]);
         s1_seed_ff <= req_tuser[3];
         s1_dst_ff  <= req_tdata[PIXEL_W-1:0];
         s1_src_ff  <= req_tdata[2*PIXEL_W-1:PIXEL_W];
         s1_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         s2_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         s2_pixel_ff <= s2_pixel_in;
         s2_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {4'b0000, s2_pixel_ff};
   assign rsp_tlast  = s2_last_ff;

   a_run_holds: assert property (@(posedge clock) disable iff (reset)
      !(s1_advance && s1_op_ff == OP_BLUR) |=> $stable(blur_run_ff))
      else $error("blur run changed without a blur transfer");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !s1_valid_ff |=> !rsp_tvalid)
      else $error("result appeared with no pixel in the input stage");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_tvalid && !rsp_tready)
      else $error("input stalled while the pipeline could move");

endmodule
